// ===== rtl/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg
// Shared types and codes for the sorted value list unit.
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int VAL_W = 32;

    // action codes carried in s_tuser
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] key;
    } t_cell_ctrl;

    // per-cell status back to the top level
    typedef struct packed {
        logic valid;
        logic lt;   // holds a value below the key
        logic bnd;  // first cell not below the key
        logic hit;  // boundary cell holds the key itself
    } t_cell_stat;

endpackage

// ===== rtl/sorted_value_list_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list_unit
// Ascending store of signed values with insert, delete and search, built as
// a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                           | tuser
//  s_      | in  | item_value[31:0]                             | action[1:0]
//  m_      | out | status, position, entry_count,               | -
//          |     | smallest_value, smallest_valid, zero pad     |
//
//  For every item, all cells compare against the key in
//  parallel and shift by one slot in the same edge; the result lands in the
//  output register. One item per cycle while m_tready is high.
//  s_tready drops only while a result waits and m_tready is low.
//  Reset (synchronous, active low) empties the row; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_value_list_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_value[31:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], position[5:2], entry_count[10:6],
                                   // smallest_value[42:11], smallest_valid[43], 0[47:44]
);
    import svl_pkg::*;

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VAL_W-1:0] w_value   [CAPACITY];
    logic signed [VAL_W-1:0] w_nvalue  [CAPACITY];
    logic                    w_nvalid  [CAPACITY];
    t_cell_stat              w_stat    [CAPACITY];
    t_cell_ctrl              w_ctrl;

    logic          w_accept;
    logic          w_found;
    logic [PW-1:0] w_pos;
    logic          w_full;
    logic          w_empty;
    t_status       w_status;
    logic [PW-1:0] w_res_pos;
    logic          w_ins;
    logic          w_del;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_m_valid;
    logic [47:0]   r_m_data;
    logic [47:0]   n_m_data;

    logic [PW+3:0] w_pos_ext;
    logic [CW+4:0] w_cnt_ext;
    logic signed [VAL_W-1:0] w_smallest;

    assign s_tready = !r_m_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;

    assign w_ctrl.ins = w_accept && w_ins;
    assign w_ctrl.del = w_accept && w_del;
    assign w_ctrl.key = $signed(s_tdata);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VAL_W-1:0] w_lv;
            logic signed [VAL_W-1:0] w_rv;
            logic                    w_lvld;
            logic                    w_llt;
            logic                    w_rvld;
            if (g == 0) begin : g_first
                assign w_lv   = '0;
                assign w_lvld = 1'b1;
                assign w_llt  = 1'b1;
            end else begin : g_mid
                assign w_lv   = w_value[g-1];
                assign w_lvld = w_stat[g-1].valid;
                assign w_llt  = w_stat[g-1].lt;
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_rv   = '0;
                assign w_rvld = 1'b0;
            end else begin : g_inner
                assign w_rv   = w_value[g+1];
                assign w_rvld = w_stat[g+1].valid;
            end
            svl_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvld),
                .i_left_lt     (w_llt),
                .i_right_value (w_rv),
                .i_right_valid (w_rvld),
                .o_value       (w_value[g]),
                .o_stat        (w_stat[g]),
                .o_next_value  (w_nvalue[g]),
                .o_next_valid  (w_nvalid[g])
            );
        end
    endgenerate

    // boundary is one-hot (or absent when every cell is below the key)
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | w_stat[i].hit;
            w_pos   = w_pos | (w_stat[i].bnd ? PW'(i) : '0);
        end
    end

    assign w_full  = w_stat[CAPACITY-1].valid;
    assign w_empty = !w_stat[0].valid;

    always_comb begin
        w_status  = ST_DONE;
        w_res_pos = '0;
        w_ins     = 1'b0;
        w_del     = 1'b0;
        case (s_tuser)
            ACT_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_res_pos = w_pos;
                    w_ins     = 1'b1;
                end
            end
            ACT_DELETE, ACT_SEARCH: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_found) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_res_pos = w_pos;
                    w_del     = (s_tuser == ACT_DELETE);
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_pos_ext  = {4'b0, w_res_pos};
    assign w_cnt_ext  = {5'b0, n_count};
    assign w_smallest = w_nvalid[0] ? w_nvalue[0] : '0;

    assign n_m_data = {4'b0, w_nvalid[0], w_smallest, w_cnt_ext[4:0],
                       w_pos_ext[3:0], w_status};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_stat[0].valid)
        else $error("entry count disagrees with first cell");

    a_full_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(CAPACITY)) == w_stat[CAPACITY-1].valid)
        else $error("entry count disagrees with last cell");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_tuser == ACT_INSERT && !w_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

endmodule

// ===== rtl/svl_cell.sv =====
// ----------------------------------------------------------------------------
// svl_cell
// One slot of the ordered row: compares its entry with the key and shifts
// toward or away from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module svl_cell (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  svl_pkg::t_cell_ctrl                     i_ctrl,
    input  logic signed [svl_pkg::VAL_W-1:0]        i_left_value,
    input  logic                                    i_left_valid,
    input  logic                                    i_left_lt,
    input  logic signed [svl_pkg::VAL_W-1:0]        i_right_value,
    input  logic                                    i_right_valid,
    output logic signed [svl_pkg::VAL_W-1:0]        o_value,
    output svl_pkg::t_cell_stat                     o_stat,
    output logic signed [svl_pkg::VAL_W-1:0]        o_next_value,
    output logic                                    o_next_valid
);
    import svl_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic                    r_valid;
    logic signed [VAL_W-1:0] n_value;
    logic                    n_valid;
    logic                    w_lt;

    assign w_lt = r_valid && (r_value < i_ctrl.key);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins && !w_lt) begin
            // boundary cell takes the key, cells above it take the left entry
            n_value = i_left_lt ? i_ctrl.key : i_left_value;
            n_valid = r_valid | i_left_valid;
        end else if (i_ctrl.del && !w_lt) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;
    assign o_next_valid = n_valid;
    assign o_stat.valid = r_valid;
    assign o_stat.lt    = w_lt;
    assign o_stat.bnd   = i_left_lt && !w_lt;
    assign o_stat.hit   = i_left_lt && !w_lt && r_valid && (r_value == i_ctrl.key);

endmodule
